// ===== hw/rtl/stereo_biquad_with_drive_core_defines.svh =====
// ----------------------------------------------------------------------------
// stereo biquad assertion macros
// shared concurrent check forms, clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef STEREO_BIQUAD_WITH_DRIVE_CORE_DEFINES_SVH
`define STEREO_BIQUAD_WITH_DRIVE_CORE_DEFINES_SVH

// same-cycle implication
`define SBQ_CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbq check failed");

// next-cycle implication
`define SBQ_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbq check failed");

`endif

// ===== hw/rtl/sbq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbq_pkg
// types, constants and arithmetic helpers for the stereo biquad core
// ----------------------------------------------------------------------------
package sbq_pkg;

  localparam int SampleBits = 24;
  localparam int StateBits  = 48;
  localparam int SampleFrac = SampleBits - 1;
  localparam int AlignShift = 10;  // product fraction 51 down to state fraction 41
  localparam int OutShift   = 18;  // state fraction 41 down to sample fraction 23

  localparam logic [17:0] DRIVE_ONE  = 18'd32768;
  localparam logic [15:0] DRIVE_MAX  = 16'd32768;
  localparam logic [25:0] RECIP3     = 26'd11184811;  // ceil(2^25 / 3)
  localparam logic signed [28:0] SAMP_ONE  = 29'sd8388608;
  localparam logic signed [24:0] SOFT_LIM  = 25'sd5592405;  // (2*one + 1) / 3

  localparam logic [1:0] SAT_NONE  = 2'd0;
  localparam logic [1:0] SAT_CUBIC = 2'd1;
  localparam logic [1:0] SAT_HARD  = 2'd2;

  localparam logic [2:0] REG_B0   = 3'd0;
  localparam logic [2:0] REG_B1   = 3'd1;
  localparam logic [2:0] REG_B2   = 3'd2;
  localparam logic [2:0] REG_A1   = 3'd3;
  localparam logic [2:0] REG_A2   = 3'd4;
  localparam logic [2:0] REG_DRV  = 3'd5;
  localparam logic [2:0] REG_SAT  = 3'd6;
  localparam logic [2:0] REG_OSM  = 3'd7;

  typedef struct packed {
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic [15:0]        drive;
    logic [1:0]         sat;
    logic               osm;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DMUL, OP_DRND, OP_SQ, OP_CU, OP_DIV, OP_FIN,
    OP_B0, OP_B1, OP_B2, OP_B3, OP_B4, OP_B5, OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DMUL, ST_DRND, ST_SQ, ST_CU, ST_DIV, ST_FIN,
    ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic chan;  // 0 left, 1 right
    logic pass;  // second left pass in 2x mode
  } cmd_t;

  typedef struct packed {
    logic drv_on;
    logic clip_done;
    logic osm;
  } stat_t;

  // product to state fraction, floor
  function automatic logic signed [49:0] align_prod(input logic signed [58:0] p);
    align_prod = 50'(p >>> AlignShift);
  endfunction

  // saturate to state width
  function automatic logic signed [47:0] clamp_state(input logic signed [50:0] v);
    logic signed [50:0] hi;
    logic signed [50:0] lo;
    hi = 51'sd140737488355327;
    lo = -51'sd140737488355328;
    if (v > hi) clamp_state = 48'(hi);
    else if (v < lo) clamp_state = 48'(lo);
    else clamp_state = 48'(v);
  endfunction

  // round state to sample fraction and saturate
  function automatic logic signed [23:0] state_to_sample(input logic signed [47:0] v);
    logic signed [30:0] r;
    r = 31'(v >>> OutShift) + 31'($unsigned(v[OutShift-1]));
    if (r > 31'sd8388607) state_to_sample = 24'sd8388607;
    else if (r < -31'sd8388608) state_to_sample = -24'sd8388608;
    else state_to_sample = 24'(r);
  endfunction

endpackage

// ===== hw/rtl/sbq_cfg.sv =====
// ----------------------------------------------------------------------------
// sbq_cfg
// register bank behind the apb-style configuration port
// ----------------------------------------------------------------------------
module sbq_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output sbq_pkg::cfg_t cfg
);
  import sbq_pkg::*;

  logic [2:0] idx;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b0    <= 32'sd268435456;
      cfg.b1    <= '0;
      cfg.b2    <= '0;
      cfg.a1    <= '0;
      cfg.a2    <= '0;
      cfg.drive <= '0;
      cfg.sat   <= SAT_NONE;
      cfg.osm   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_B0:  cfg.b0    <= pwdata;
        REG_B1:  cfg.b1    <= pwdata;
        REG_B2:  cfg.b2    <= pwdata;
        REG_A1:  cfg.a1    <= pwdata;
        REG_A2:  cfg.a2    <= pwdata;
        REG_DRV: cfg.drive <= pwdata[15:0];
        REG_SAT: cfg.sat   <= pwdata[1:0];
        REG_OSM: cfg.osm   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_B0:  prdata = cfg.b0;
      REG_B1:  prdata = cfg.b1;
      REG_B2:  prdata = cfg.b2;
      REG_A1:  prdata = cfg.a1;
      REG_A2:  prdata = cfg.a2;
      REG_DRV: prdata = {16'd0, cfg.drive};
      REG_SAT: prdata = {30'd0, cfg.sat};
      REG_OSM: prdata = {31'd0, cfg.osm};
      default: prdata = '0;
    endcase
  end
endmodule

// ===== hw/rtl/sbq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbq_ctrl
// sequencer that steps the shared multiplier datapath through one sample pair
// ----------------------------------------------------------------------------
module sbq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  sbq_pkg::stat_t stat,
  output sbq_pkg::cmd_t  cmd
);
  import sbq_pkg::*;

  state_t state, state_next;
  logic   chan, chan_next;
  logic   pass, pass_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    chan_next  = chan;
    pass_next  = pass;
    case (state)
      ST_IDLE: if (in_valid) begin
        chan_next  = 1'b0;
        pass_next  = 1'b0;
        state_next = stat.drv_on ? ST_DMUL : ST_B0;
      end
      ST_DMUL: state_next = ST_DRND;
      ST_DRND: if (stat.clip_done) begin
        state_next = chan ? ST_B0 : ST_DMUL;
        chan_next  = !chan;
      end else begin
        state_next = ST_SQ;
      end
      ST_SQ:  state_next = ST_CU;
      ST_CU:  state_next = ST_DIV;
      ST_DIV: state_next = ST_FIN;
      ST_FIN: begin
        state_next = chan ? ST_B0 : ST_DMUL;
        chan_next  = !chan;
      end
      ST_B0: state_next = ST_B1;
      ST_B1: state_next = ST_B2;
      ST_B2: state_next = ST_B3;
      ST_B3: state_next = ST_B4;
      ST_B4: state_next = ST_B5;
      ST_B5: begin
        if (chan) begin
          state_next = ST_DONE;
        end else if (stat.osm && !pass) begin
          state_next = ST_B0;
          pass_next  = 1'b1;
        end else begin
          state_next = ST_B0;
          chan_next  = 1'b1;
        end
      end
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd.chan = chan;
    cmd.pass = pass;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? OP_LOAD : OP_NONE;
      end
      ST_DMUL: cmd.op = OP_DMUL;
      ST_DRND: cmd.op = OP_DRND;
      ST_SQ:   cmd.op = OP_SQ;
      ST_CU:   cmd.op = OP_CU;
      ST_DIV:  cmd.op = OP_DIV;
      ST_FIN:  cmd.op = OP_FIN;
      ST_B0:   cmd.op = OP_B0;
      ST_B1:   cmd.op = OP_B1;
      ST_B2:   cmd.op = OP_B2;
      ST_B3:   cmd.op = OP_B3;
      ST_B4:   cmd.op = OP_B4;
      ST_B5:   cmd.op = OP_B5;
      ST_DONE: cmd.op = out_free ? OP_OUT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  // state and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chan      <= 1'b0;
      pass      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
      pass  <= pass_next;
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

// ===== hw/rtl/sbq_dp.sv =====
// ----------------------------------------------------------------------------
// sbq_dp
// shared multiplier datapath: drive, clipper, biquad passes and output beat
// ----------------------------------------------------------------------------
module sbq_dp (
  input  logic                clk,
  input  logic                rst,
  input  sbq_pkg::cfg_t       cfg,
  input  sbq_pkg::cmd_t       cmd,
  output sbq_pkg::stat_t      stat,
  input  logic signed [23:0]  left_in,
  input  logic signed [23:0]  right_in,
  output logic signed [23:0]  left_out,
  output logic signed [23:0]  right_out
);
  import sbq_pkg::*;

  logic signed [23:0] raw_l, raw_r;
  logic signed [24:0] xl, xr;
  logic signed [47:0] ld1, ld2, rd1, rd2;
  logic signed [49:0] t;
  logic signed [47:0] n1;
  logic signed [23:0] y, y0, lres, rres;
  logic [23:0]        a_mag;
  logic               neg;
  logic signed [58:0] prod;

  logic signed [32:0] mul_a;
  logic signed [25:0] mul_b;
  logic [15:0]        dcl;
  logic [17:0]        gain;
  logic signed [24:0] x_sel;
  logic signed [47:0] d1_sel, d2_sel;
  logic signed [28:0] v;
  logic signed [24:0] clip_res, fin_res, r_mag;
  logic [23:0]        sq, quot;
  logic [24:0]        cu1;
  logic signed [47:0] acc, n1_c, n2_c;
  logic signed [23:0] y_c;
  logic signed [24:0] avg_sum;

  // drive gain and channel selects
  assign dcl    = (cfg.drive > DRIVE_MAX) ? DRIVE_MAX : cfg.drive;
  assign gain   = DRIVE_ONE + 18'(dcl) + 18'({dcl, 1'b0});
  assign x_sel  = cmd.chan ? xr : xl;
  assign d1_sel = cmd.chan ? rd1 : ld1;
  assign d2_sel = cmd.chan ? rd2 : ld2;
  assign sq     = prod[46:23];
  assign cu1    = 25'(prod[46:23]) + 25'd1;
  assign quot   = prod[48:25];

  assign stat.drv_on    = (dcl != 16'd0) && (cfg.sat inside {SAT_CUBIC, SAT_HARD});
  assign stat.osm       = cfg.osm;
  assign stat.clip_done = (cfg.sat == SAT_HARD) || (v > SAMP_ONE) || (v < -SAMP_ONE);

  // driven value, its clip where no cubic is needed, and the cubic result
  always_comb begin
    v = 29'($signed(prod[42:15])) + 29'($unsigned(prod[14]));
    if (cfg.sat == SAT_HARD) begin
      if (v > SAMP_ONE) clip_res = 25'(SAMP_ONE);
      else if (v < -SAMP_ONE) clip_res = -25'(SAMP_ONE);
      else clip_res = 25'(v);
    end else begin
      clip_res = (v < 0) ? -SOFT_LIM : SOFT_LIM;
    end
    r_mag   = $signed({1'b0, a_mag}) - $signed({1'b0, quot});
    fin_res = neg ? -r_mag : r_mag;
  end

  // biquad sums and the 2x-mode average
  always_comb begin
    acc  = clamp_state(51'(align_prod(prod)) + 51'(d1_sel));
    y_c  = state_to_sample(acc);
    n1_c = clamp_state(51'(t) - 51'(align_prod(prod)) + 51'(d2_sel));
    n2_c = clamp_state(51'(t) - 51'(align_prod(prod)));
    avg_sum = 25'(y0) + 25'(y) + 25'sd1;
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_DMUL: begin
        mul_a = 33'(cmd.chan ? raw_r : raw_l);
        mul_b = $signed({8'd0, gain});
      end
      OP_DRND: begin
        mul_a = $signed({9'd0, (v < 0) ? 24'(-v) : 24'(v)});
        mul_b = $signed({2'd0, (v < 0) ? 24'(-v) : 24'(v)});
      end
      OP_SQ: begin
        mul_a = $signed({9'd0, a_mag});
        mul_b = $signed({2'd0, sq});
      end
      OP_CU: begin
        mul_a = $signed({8'd0, cu1});
        mul_b = $signed(RECIP3);
      end
      OP_B0: begin
        mul_a = 33'(cfg.b0);
        mul_b = 26'(x_sel);
      end
      OP_B1: begin
        mul_a = 33'(cfg.b1);
        mul_b = 26'(x_sel);
      end
      OP_B2: begin
        mul_a = 33'(cfg.a1);
        mul_b = 26'(y);
      end
      OP_B3: begin
        mul_a = 33'(cfg.b2);
        mul_b = 26'(x_sel);
      end
      OP_B4: begin
        mul_a = 33'(cfg.a2);
        mul_b = 26'(y);
      end
      default: ;
    endcase
  end

  // shared product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      ld1 <= '0;
      ld2 <= '0;
      rd1 <= '0;
      rd2 <= '0;
    end else if (cmd.op == OP_B5) begin
      if (cmd.chan) begin
        rd1 <= n1;
        rd2 <= n2_c;
      end else begin
        ld1 <= n1;
        ld2 <= n2_c;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        raw_l <= left_in;
        raw_r <= right_in;
        xl    <= 25'(left_in);
        xr    <= 25'(right_in);
      end
      OP_DRND: begin
        a_mag <= (v < 0) ? 24'(-v) : 24'(v);
        neg   <= (v < 0);
        if (stat.clip_done) begin
          if (cmd.chan) xr <= clip_res;
          else xl <= clip_res;
        end
      end
      // quotient is in the product register during this step only
      OP_DIV: begin
        if (cmd.chan) xr <= fin_res;
        else xl <= fin_res;
      end
      OP_B1: y <= y_c;
      OP_B2: t <= align_prod(prod);
      OP_B3: n1 <= n1_c;
      OP_B4: t <= align_prod(prod);
      OP_B5: begin
        if (cmd.chan) begin
          rres <= y;
        end else begin
          y0   <= y;
          lres <= cmd.pass ? 24'(avg_sum >>> 1) : y;
        end
      end
      OP_OUT: begin
        left_out  <= lres;
        right_out <= rres;
      end
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/stereo_biquad_with_drive_core.sv =====
// ----------------------------------------------------------------------------
// stereo_biquad_with_drive_core
// stereo drive, clipper and transposed direct form ii biquad
// ----------------------------------------------------------------------------
// One stereo pair goes in per beat and one filtered pair comes out. Every
// product is formed by a single registered 33x26 multiplier, one product a
// cycle, so the steps per pair are set by that unit: a load step, then per
// channel, when drive is on, the drive steps dmul and drnd (plus sq, cu, div
// and fin for the cubic clip when it is not limited), then the biquad steps
// b0 to b5 per pass, with two left passes in 2x mode, and an output step to
// hand over the result. A new pair is taken while the last result still
// waits at the output. Configuration is to be written by the user through
// the apb-style port while the core is idle; the core does not enforce this.
module stereo_biquad_with_drive_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] left_in,
  input  logic signed [23:0] right_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] left_out,
  output logic signed [23:0] right_out
);
  import sbq_pkg::*;
  `include "stereo_biquad_with_drive_core_defines.svh"

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  sbq_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  sbq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  sbq_dp u_dp (
    .clk, .rst, .cfg, .cmd, .stat, .left_in, .right_in, .left_out, .right_out
  );

  // a taken pair keeps the core busy for at least the next cycle
  `SBQ_CHK_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  // a result only appears as the sequencer returns to idle
  `SBQ_CHK_SAME(a_result_at_idle, $rose(out_valid), $rose(in_ready))
  // output beat registers only move when the slot is free
  `SBQ_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_out))
endmodule
